FILE: rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and helper functions for the infix-to-postfix
// converter: stack sizing, character codes, operator ranks, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  // Operator stack sizing
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // Rank codes, offset by one so that "no rank" sorts lowest
  typedef logic [1:0] rank_t;
  localparam rank_t RANK_NONE = 2'd0;
  localparam rank_t RANK_ADD  = 2'd1;
  localparam rank_t RANK_MUL  = 2'd2;
  localparam rank_t RANK_POW  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OPD,
    S_FETCH,
    S_CHECK,
    S_FINISH,
    S_TERM
  } state_t;

  function automatic rank_t rank_of(input logic [7:0] c);
    rank_t r;
    case (c)
      CH_PLUS, CH_MINUS:         r = RANK_ADD;
      CH_STAR, CH_SLASH, CH_PCT: r = RANK_MUL;
      CH_CARET:                  r = RANK_POW;
      default:                   r = RANK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard conversion of an infix character stream to postfix, with a
// memory-based operator stack walked one entry at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Sequencing: operands pass through S_OPD; an operator, ')' or end marker pops
//   via S_FETCH (read) and S_CHECK (compare), then S_FINISH pushes the operator
//   or drops the '('; an end marker then emits a NUL terminator from S_TERM.
// Throughput: a request is taken only in idle (every cycle for '(', which
//   stays idle); each pop is a read state followed by a compare state.
// Reset: rst is synchronous, active high; it clears the stack count, overflow
//   flag, config bit and output valid. Output stalls hold the sequencer.
`default_nettype none

module infix_to_postfix_converter_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  // config register
  input  wire logic       cfg_write_en,
  input  wire logic       cfg_write_data,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_expression,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      char_out,
  output logic            last_of_run,
  output logic            expression_done,
  output logic            overflow
);
  import itp_pkg::*;

  // State
  state_t            state, state_next;
  logic [CNT_W-1:0]  stack_count;
  logic [7:0]        stack_mem [STACK_DEPTH];
  logic [7:0]        rd_data;
  logic [7:0]        cur_char;
  logic              cur_end;
  logic              pend_valid;
  logic [7:0]        pend_char;
  logic              ovf_seen;
  logic              power_right_assoc;

  // Control from the output decode
  logic              in_accept;
  logic              out_free;
  logic              emit;
  logic [7:0]        emit_char;
  logic              emit_last;
  logic              emit_done;
  logic              do_push;
  logic [7:0]        push_char;
  logic              do_pop;
  logic              do_discard;
  logic              pend_clear;
  logic              clear_ovf;
  logic              pop_cond;
  logic              stack_full;
  logic [IDX_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  count_dec;
  rank_t             in_rank;
  rank_t             top_rank;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign stack_full = (stack_count >= CNT_W'(STACK_DEPTH));
  assign count_dec  = stack_count - CNT_W'(1);
  assign rd_addr    = count_dec[IDX_W-1:0];

  // Shared rank compare: decides whether the top entry is popped
  assign in_rank  = rank_of(cur_char);
  assign top_rank = rank_of(rd_data);
  always_comb begin
    if (cur_end) begin
      pop_cond = 1'b1;
    end else if (cur_char == CH_RPAREN) begin
      pop_cond = (rd_data != CH_LPAREN);
    end else if ((cur_char == CH_CARET) && power_right_assoc) begin
      pop_cond = (in_rank < top_rank);
    end else begin
      pop_cond = (in_rank <= top_rank);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (!end_of_expression && is_operand(char_in)) begin
            state_next = S_OPD;
          end else if (!end_of_expression && (char_in == CH_LPAREN)) begin
            state_next = S_IDLE;
          end else if (stack_count == '0) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_OPD: begin
        if (out_free) state_next = S_IDLE;
      end
      S_FETCH: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!pop_cond) begin
          state_next = S_FINISH;
        end else if (!pend_valid || out_free) begin
          state_next = (count_dec == '0) ? S_FINISH : S_FETCH;
        end
      end
      S_FINISH: begin
        if (!pend_valid || out_free) state_next = cur_end ? S_TERM : S_IDLE;
      end
      S_TERM: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output decode
  always_comb begin
    emit       = 1'b0;
    emit_char  = CH_NUL;
    emit_last  = 1'b0;
    emit_done  = 1'b0;
    do_push    = 1'b0;
    push_char  = char_in;
    do_pop     = 1'b0;
    do_discard = 1'b0;
    pend_clear = 1'b0;
    clear_ovf  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_accept && !end_of_expression && (char_in == CH_LPAREN)) begin
          do_push = 1'b1;
        end
      end
      S_OPD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = cur_char;
          emit_last = 1'b1;
        end
      end
      S_CHECK: begin
        // popped entry waits in pend until we know whether it ends the run
        if (pop_cond && (!pend_valid || out_free)) begin
          emit      = pend_valid;
          emit_char = pend_char;
          do_pop    = 1'b1;
        end
      end
      S_FINISH: begin
        if (!pend_valid || out_free) begin
          emit       = pend_valid;
          emit_char  = pend_char;
          emit_last  = !cur_end;
          pend_clear = 1'b1;
          if (!cur_end) begin
            if (cur_char == CH_RPAREN) begin
              do_discard = (stack_count != '0);
            end else begin
              do_push   = 1'b1;
              push_char = cur_char;
            end
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_NUL;
          emit_last = 1'b1;
          emit_done = 1'b1;
          clear_ovf = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      stack_count       <= '0;
      pend_valid        <= 1'b0;
      ovf_seen          <= 1'b0;
      power_right_assoc <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) power_right_assoc <= cfg_write_data;
      // stack count
      if (do_push && !stack_full) begin
        stack_count <= stack_count + CNT_W'(1);
      end else if (do_pop || do_discard) begin
        stack_count <= count_dec;
      end
      // pending popped entry
      if (do_pop) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      // sticky overflow
      if (do_push && stack_full) begin
        ovf_seen <= 1'b1;
      end else if (clear_ovf) begin
        ovf_seen <= 1'b0;
      end
    end
  end

  // Request capture and pending payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_char <= char_in;
      cur_end  <= end_of_expression;
    end
    if (do_pop) pend_char <= rd_data;
  end

  // Operator stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_push && !stack_full) stack_mem[stack_count[IDX_W-1:0]] <= push_char;
    if (state == S_FETCH) rd_data <= stack_mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_out        <= emit_char;
      last_of_run     <= emit_last;
      expression_done <= emit_done;
      overflow        <= ovf_seen;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result written over an unaccepted result");

  a_term_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_TERM) |-> (stack_count == '0))
    else $error("terminator with entries left on the stack");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_FETCH || state == S_CHECK || state == S_FINISH))
    else $error("pending entry outside a pop run");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (do_pop || do_discard) |-> (stack_count != '0))
    else $error("pop from empty stack");

endmodule

`default_nettype wire
